### src/tmcg_pkg.sv
`timescale 1ns / 1ps
// Package for the text-mode character generator: default sizes, opcodes,
// configuration register indexes and the 16-color palette. No dependencies.
package tmcg_pkg;

  localparam int TEXT_COLS_DEF   = 80;
  localparam int TEXT_ROWS_DEF   = 25;
  localparam int FONT_SLOTS_DEF  = 4;
  localparam int GLYPH_LINES_DEF = 16;

  localparam logic [3:0] UNDERLINE_LINE = 4'd14;
  localparam logic [7:0] ROW_ALL_ON     = 8'hFF;
  localparam logic [1:0] MAX_SHIFT      = 2'd2;

  typedef enum logic [1:0] {
    OP_CELL   = 2'd0,
    OP_FLAGS  = 2'd1,
    OP_FONT   = 2'd2,
    OP_RENDER = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    CFG_SCALE_LOG2    = 2'd0,
    CFG_CURSOR_ENABLE = 2'd1,
    CFG_CURSOR_COL    = 2'd2,
    CFG_CURSOR_ROW    = 2'd3
  } cfg_index_t;

  function automatic logic [23:0] palette_rgb(input logic [3:0] idx);
    logic [23:0] rgb;
    unique case (idx)
      4'd0:    rgb = 24'h000000;
      4'd1:    rgb = 24'h0000AA;
      4'd2:    rgb = 24'h00AA00;
      4'd3:    rgb = 24'h00AAAA;
      4'd4:    rgb = 24'hAA0000;
      4'd5:    rgb = 24'hAA00AA;
      4'd6:    rgb = 24'hAA5500;
      4'd7:    rgb = 24'hAAAAAA;
      4'd8:    rgb = 24'h555555;
      4'd9:    rgb = 24'h5555FF;
      4'd10:   rgb = 24'h55FF55;
      4'd11:   rgb = 24'h55FFFF;
      4'd12:   rgb = 24'hFF5555;
      4'd13:   rgb = 24'hFF55FF;
      4'd14:   rgb = 24'hFFFF55;
      default: rgb = 24'hFFFFFF;
    endcase
    return rgb;
  endfunction

endpackage

### src/tmcg_ram.sv
`timescale 1ns / 1ps
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module tmcg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### src/text_mode_character_generator_top.sv
`timescale 1ns / 1ps
// Text-mode character generator top level: text, flag and font memories
// and the render sequencer. Depends on tmcg_pkg and tmcg_ram.

// After reset the block sweeps the cell memories to zero, one cell per
// clock, with busy high; configuration writes are taken throughout
// (cfg_ready is always high). A write transaction passes through the
// execute state and returns to idle. A render transaction steps through
// memory access (cell read, font read, pattern set-up) and then gives one
// pixel per clock; the next transaction is accepted only back in idle.
// Pixels come out on out_valid, one cycle each, and cannot be held off;
// out_last_pixel marks the end of a run.
module text_mode_character_generator_top
  #(
  parameter int TEXT_COLS   = tmcg_pkg::TEXT_COLS_DEF,
  parameter int TEXT_ROWS   = tmcg_pkg::TEXT_ROWS_DEF,
  parameter int FONT_SLOTS  = tmcg_pkg::FONT_SLOTS_DEF,
  parameter int GLYPH_LINES = tmcg_pkg::GLYPH_LINES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  tmcg_pkg::opcode_t    in_opcode,
  input  logic [6:0]           in_text_col,
  input  logic [4:0]           in_text_row,
  input  logic [5:0]           in_line_in_cell,
  input  logic [7:0]           in_char_code,
  input  logic [7:0]           in_attribute,
  input  logic [1:0]           in_font_slot,
  input  logic [3:0]           in_glyph_row,
  input  logic [7:0]           in_font_bits,
  input  logic                 in_underline,
  input  logic                 in_cursor_phase_on,
  output logic                 out_valid,
  output logic [23:0]          out_pixel_rgb,
  output logic [4:0]           out_pixel_offset,
  output logic                 out_last_pixel,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  tmcg_pkg::cfg_index_t cfg_index,
  input  logic [6:0]           cfg_data
);
  import tmcg_pkg::*;

  localparam int CELLS      = TEXT_COLS * TEXT_ROWS;
  localparam int CA_W       = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int FONT_DEPTH = FONT_SLOTS * 256 * GLYPH_LINES;
  localparam int FA_W       = $clog2(FONT_DEPTH);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_CELL,
    S_FONT,
    S_PIX
  } state_t;

  state_t state_r;
  logic [CA_W-1:0] clr_cnt_r;

  logic [1:0] scale_log2_r;
  logic       cursor_enable_r;
  logic [6:0] cursor_col_r;
  logic [4:0] cursor_row_r;

  opcode_t    op_r;
  logic [6:0] col_r;
  logic [4:0] row_r;
  logic [5:0] line_r;
  logic [7:0] ch_r;
  logic [7:0] attr_r;
  logic [1:0] slot_r;
  logic [3:0] grow_r;
  logic [7:0] bits_r;
  logic       ul_r;
  logic       phase_r;

  logic [3:0]  gline_r;
  logic        cursor_hit_r;
  logic        ul_line_r;
  logic [7:0]  cattr_r;
  logic [7:0]  pattern_r;
  logic [23:0] fg_r;
  logic [23:0] bg_r;
  logic [4:0]  pix_cnt_r;

  logic        out_valid_r;
  logic [23:0] out_rgb_r;
  logic [4:0]  out_offset_r;
  logic        out_last_r;

  logic [12:0] cell_sum;
  logic [CA_W-1:0] cell_addr;
  logic        in_grid;
  logic        slot_ok;
  logic        grow_ok;
  logic [1:0]  shift;
  logic        line_ok;
  logic [5:0]  gline_full;
  logic [4:0]  width_m1;
  logic [2:0]  bit_idx;
  logic        pix_set;
  logic        pix_last;

  logic            cell_we;
  logic [CA_W-1:0] cell_ram_addr;
  logic [15:0]     cell_wdata;
  logic [15:0]     cell_rdata;
  logic            flag_we;
  logic [2:0]      flag_wdata;
  logic [2:0]      flag_rdata;
  logic            font_we;
  logic [16:0]     font_sum;
  logic [FA_W-1:0] font_addr;
  logic [7:0]      font_rdata;
  logic [7:0]      pattern_nxt;

  always_comb begin
    cell_sum   = 13'(row_r) * 13'(TEXT_COLS) + 13'(col_r);
    cell_addr  = cell_sum[CA_W-1:0];
    in_grid    = ({1'b0, col_r} < 8'(TEXT_COLS)) && ({1'b0, row_r} < 6'(TEXT_ROWS));
    slot_ok    = {1'b0, slot_r} < 3'(FONT_SLOTS);
    grow_ok    = {1'b0, grow_r} < 5'(GLYPH_LINES);
    shift      = (scale_log2_r > MAX_SHIFT) ? MAX_SHIFT : scale_log2_r;
    line_ok    = {1'b0, line_r} < (7'(GLYPH_LINES) << shift);
    gline_full = line_r >> shift;
    width_m1   = 5'((6'd8 << shift) - 6'd1);
    bit_idx    = 3'(pix_cnt_r >> shift);
    pix_set    = pattern_r[3'd7 - bit_idx];
    pix_last   = (pix_cnt_r == width_m1);
  end

  // Memory ports: the clearing sweep owns the cell memories after reset.
  always_comb begin
    cell_ram_addr = (state_r == S_CLEAR) ? clr_cnt_r : cell_addr;
    cell_we       = (state_r == S_CLEAR) || (state_r == S_EXEC && op_r == OP_CELL && in_grid);
    cell_wdata    = (state_r == S_CLEAR) ? 16'd0 : {attr_r, ch_r};
    flag_we       = (state_r == S_CLEAR) ||
                    (state_r == S_EXEC && op_r == OP_FLAGS && in_grid && slot_ok);
    flag_wdata    = (state_r == S_CLEAR) ? 3'd0 : {slot_r, ul_r};
    font_we       = (state_r == S_EXEC) && (op_r == OP_FONT) && slot_ok && grow_ok;
    if (state_r == S_CELL) begin
      font_sum = 17'({flag_rdata[2:1], cell_rdata[7:0]}) * 17'(GLYPH_LINES) + 17'(gline_r);
    end else begin
      font_sum = 17'({slot_r, ch_r}) * 17'(GLYPH_LINES) + 17'(grow_r);
    end
    font_addr = font_sum[FA_W-1:0];
    pattern_nxt = ul_line_r ? ROW_ALL_ON : font_rdata;
    if (cursor_hit_r) begin
      pattern_nxt = ~pattern_nxt;
    end
  end

  tmcg_ram #(.WIDTH(16), .DEPTH(CELLS)) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .addr  (cell_ram_addr),
    .wdata (cell_wdata),
    .rdata (cell_rdata)
  );

  tmcg_ram #(.WIDTH(3), .DEPTH(CELLS)) u_flag_ram (
    .clk   (clk),
    .we    (flag_we),
    .addr  (cell_ram_addr),
    .wdata (flag_wdata),
    .rdata (flag_rdata)
  );

  tmcg_ram #(.WIDTH(8), .DEPTH(FONT_DEPTH)) u_font_ram (
    .clk   (clk),
    .we    (font_we),
    .addr  (font_addr),
    .wdata (bits_r),
    .rdata (font_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_log2_r    <= 2'd0;
      cursor_enable_r <= 1'b1;
      cursor_col_r    <= 7'd0;
      cursor_row_r    <= 5'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SCALE_LOG2:    scale_log2_r    <= cfg_data[1:0];
        CFG_CURSOR_ENABLE: cursor_enable_r <= cfg_data[0];
        CFG_CURSOR_COL:    cursor_col_r    <= cfg_data;
        CFG_CURSOR_ROW:    cursor_row_r    <= cfg_data[4:0];
        default:           ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      pix_cnt_r   <= 5'd0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == CA_W'(CELLS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            op_r    <= in_opcode;
            col_r   <= in_text_col;
            row_r   <= in_text_row;
            line_r  <= in_line_in_cell;
            ch_r    <= in_char_code;
            attr_r  <= in_attribute;
            slot_r  <= in_font_slot;
            grow_r  <= in_glyph_row;
            bits_r  <= in_font_bits;
            ul_r    <= in_underline;
            phase_r <= in_cursor_phase_on;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          gline_r      <= gline_full[3:0];
          cursor_hit_r <= cursor_enable_r && phase_r &&
                          (col_r == cursor_col_r) && (row_r == cursor_row_r);
          if (op_r == OP_RENDER && in_grid && line_ok) begin
            state_r <= S_CELL;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_CELL: begin
          cattr_r   <= cell_rdata[15:8];
          ul_line_r <= flag_rdata[0] && (gline_r == UNDERLINE_LINE);
          state_r   <= S_FONT;
        end
        S_FONT: begin
          pattern_r <= pattern_nxt;
          fg_r      <= palette_rgb(cattr_r[3:0]);
          bg_r      <= palette_rgb(cattr_r[7:4]);
          pix_cnt_r <= 5'd0;
          state_r   <= S_PIX;
        end
        S_PIX: begin
          out_valid_r  <= 1'b1;
          out_rgb_r    <= pix_set ? fg_r : bg_r;
          out_offset_r <= pix_cnt_r;
          out_last_r   <= pix_last;
          pix_cnt_r    <= pix_cnt_r + 5'd1;
          if (pix_last) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy             = (state_r != S_IDLE);
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_pixel_rgb    = out_rgb_r;
  assign out_pixel_offset = out_offset_r;
  assign out_last_pixel   = out_last_r;

  a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_pixel |=> !out_valid)
    else $error("pixel after end of run");

  a_accept_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> !out_valid)
    else $error("pixel right after accepting a transaction");

  a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_pixel |=>
      out_valid && (out_pixel_offset == $past(out_pixel_offset) + 5'd1))
    else $error("gap or skip inside a pixel run");

  a_last_width: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_pixel |->
      (out_pixel_offset == 5'd7) || (out_pixel_offset == 5'd15) ||
      (out_pixel_offset == 5'd31))
    else $error("run length is not 8, 16 or 32");

endmodule
